// ----- design/teoq_pkg.sv -----
`default_nettype none
package teoq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF  = 64;
  localparam int unsigned TIME_BITS_DEF    = 32;
  localparam int unsigned PROCESS_BITS_DEF = 8;

  localparam int unsigned STATE_BITS  = 3;
  localparam int unsigned CMD_BITS    = 2;
  localparam int unsigned STATUS_BITS = 2;

  localparam logic [CMD_BITS-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_POP    = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CMD_BITS-1:0] CMD_NONE   = 2'd3;

  localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_EMPTY     = 2'd2;
  localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic sample;
    logic add;
    logic pop;
    logic rem;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ----- design/timestamp_ordered_event_queue_unit.sv -----
// an accepted command is registered and sets busy; busy then registers the result beat
// start is refused while busy, which is high for the cycle after each accept
// accept registers each cell's compare against the command; busy then shifts the cell row
// reset empties the queue at once and clears the result strobe; no clearing pass
// the receiver cannot stall: each result beat is shown for exactly one cycle
`default_nettype none
module timestamp_ordered_event_queue_unit #(
  parameter int unsigned QUEUE_DEPTH  = teoq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned TIME_BITS    = teoq_pkg::TIME_BITS_DEF,
  parameter int unsigned PROCESS_BITS = teoq_pkg::PROCESS_BITS_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               start,
  output logic                              busy,
  input  wire [teoq_pkg::CMD_BITS-1:0]      cmd_i,
  input  wire [TIME_BITS-1:0]               event_time_i,
  input  wire [PROCESS_BITS-1:0]            process_id_i,
  input  wire [teoq_pkg::STATE_BITS-1:0]    old_state_i,
  input  wire [teoq_pkg::STATE_BITS-1:0]    new_state_i,
  output logic                              result_valid_o,
  output logic [teoq_pkg::STATUS_BITS-1:0]  status_o,
  output logic [TIME_BITS-1:0]              popped_time_o,
  output logic [PROCESS_BITS-1:0]           popped_process_o,
  output logic [teoq_pkg::STATE_BITS-1:0]   popped_old_state_o,
  output logic [teoq_pkg::STATE_BITS-1:0]   popped_new_state_o,
  output logic                              head_valid_o,
  output logic [TIME_BITS-1:0]              head_time_o
);

  localparam int unsigned LEVELS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic                            busy_q, busy_d;
  logic [teoq_pkg::CMD_BITS-1:0]   cmd_q;
  logic [TIME_BITS-1:0]            new_time_q;
  logic [PROCESS_BITS-1:0]         new_proc_q;
  logic [teoq_pkg::STATE_BITS-1:0] new_os_q, new_ns_q;
  logic                            accept;

  logic                            rv_q;
  logic [teoq_pkg::STATUS_BITS-1:0] status_q, status_d;
  logic [TIME_BITS-1:0]            pop_time_q, pop_time_d;
  logic [PROCESS_BITS-1:0]         pop_proc_q, pop_proc_d;
  logic [teoq_pkg::STATE_BITS-1:0] pop_os_q, pop_os_d, pop_ns_q, pop_ns_d;

  teoq_pkg::cell_ctrl_t ctrl;

  logic                            c_gt    [QUEUE_DEPTH];
  logic                            c_valid [QUEUE_DEPTH];
  logic [TIME_BITS-1:0]            c_time  [QUEUE_DEPTH];
  logic [PROCESS_BITS-1:0]         c_proc  [QUEUE_DEPTH];
  logic [teoq_pkg::STATE_BITS-1:0] c_os    [QUEUE_DEPTH];
  logic [teoq_pkg::STATE_BITS-1:0] c_ns    [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]          match_vec;
  logic [QUEUE_DEPTH-1:0]          seen_vec;
  logic                            found;
  logic                            full;
  logic                            empty;

  assign accept = start && !busy_q;
  assign busy   = busy_q;
  assign busy_d = accept;
  assign full   = c_valid[QUEUE_DEPTH-1];
  assign empty  = !c_valid[0];

  always_comb begin
    ctrl.sample = accept;
    ctrl.add    = busy_q && (cmd_q == teoq_pkg::CMD_ADD) && !full;
    ctrl.pop    = busy_q && (cmd_q == teoq_pkg::CMD_POP) && !empty;
    ctrl.rem    = busy_q && (cmd_q == teoq_pkg::CMD_REMOVE);
  end

  // first match and everything behind it shifts forward by one
  always_comb begin
    seen_vec = match_vec;
    for (int lv = 0; lv < LEVELS; lv++) begin
      seen_vec = seen_vec | (seen_vec << (1 << lv));
    end
    found = seen_vec[QUEUE_DEPTH-1];
  end

  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    logic                            l_gt, l_valid, r_valid;
    logic [TIME_BITS-1:0]            l_time, r_time;
    logic [PROCESS_BITS-1:0]         l_proc, r_proc;
    logic [teoq_pkg::STATE_BITS-1:0] l_os, l_ns, r_os, r_ns;

    if (k == 0) begin : g_first
      assign l_gt    = 1'b0;
      assign l_valid = 1'b0;
      assign l_time  = '0;
      assign l_proc  = '0;
      assign l_os    = '0;
      assign l_ns    = '0;
    end else begin : g_mid_left
      assign l_gt    = c_gt[k-1];
      assign l_valid = c_valid[k-1];
      assign l_time  = c_time[k-1];
      assign l_proc  = c_proc[k-1];
      assign l_os    = c_os[k-1];
      assign l_ns    = c_ns[k-1];
    end

    if (k == QUEUE_DEPTH-1) begin : g_last
      assign r_valid = 1'b0;
      assign r_time  = '0;
      assign r_proc  = '0;
      assign r_os    = '0;
      assign r_ns    = '0;
    end else begin : g_mid_right
      assign r_valid = c_valid[k+1];
      assign r_time  = c_time[k+1];
      assign r_proc  = c_proc[k+1];
      assign r_os    = c_os[k+1];
      assign r_ns    = c_ns[k+1];
    end

    teoq_cell #(
      .TIME_BITS    (TIME_BITS),
      .PROCESS_BITS (PROCESS_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .cmp_time_i    (event_time_i),
      .cmp_proc_i    (process_id_i),
      .new_time_i    (new_time_q),
      .new_proc_i    (new_proc_q),
      .new_os_i      (new_os_q),
      .new_ns_i      (new_ns_q),
      .left_gt_i     (l_gt),
      .left_valid_i  (l_valid),
      .left_time_i   (l_time),
      .left_proc_i   (l_proc),
      .left_os_i     (l_os),
      .left_ns_i     (l_ns),
      .right_valid_i (r_valid),
      .right_time_i  (r_time),
      .right_proc_i  (r_proc),
      .right_os_i    (r_os),
      .right_ns_i    (r_ns),
      .shift_rem_i   (seen_vec[k]),
      .gt_o          (c_gt[k]),
      .match_o       (match_vec[k]),
      .valid_o       (c_valid[k]),
      .time_o        (c_time[k]),
      .proc_o        (c_proc[k]),
      .os_o          (c_os[k]),
      .ns_o          (c_ns[k])
    );
  end

  always_comb begin
    status_d   = teoq_pkg::STATUS_OK;
    pop_time_d = '0;
    pop_proc_d = '0;
    pop_os_d   = '0;
    pop_ns_d   = '0;
    unique case (cmd_q)
      teoq_pkg::CMD_ADD: begin
        if (full) status_d = teoq_pkg::STATUS_FULL;
      end
      teoq_pkg::CMD_POP: begin
        if (empty) begin
          status_d = teoq_pkg::STATUS_EMPTY;
        end else begin
          pop_time_d = c_time[0];
          pop_proc_d = c_proc[0];
          pop_os_d   = c_os[0];
          pop_ns_d   = c_ns[0];
        end
      end
      teoq_pkg::CMD_REMOVE: begin
        if (!found) status_d = teoq_pkg::STATUS_NOT_FOUND;
      end
      default: begin
        status_d = teoq_pkg::STATUS_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rv_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      rv_q   <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q      <= cmd_i;
      new_time_q <= event_time_i;
      new_proc_q <= process_id_i;
      new_os_q   <= old_state_i;
      new_ns_q   <= new_state_i;
    end
    if (busy_q) begin
      status_q   <= status_d;
      pop_time_q <= pop_time_d;
      pop_proc_q <= pop_proc_d;
      pop_os_q   <= pop_os_d;
      pop_ns_q   <= pop_ns_d;
    end
  end

  assign result_valid_o     = rv_q;
  assign status_o           = status_q;
  assign popped_time_o      = pop_time_q;
  assign popped_process_o   = pop_proc_q;
  assign popped_old_state_o = pop_os_q;
  assign popped_new_state_o = pop_ns_q;
  assign head_valid_o       = c_valid[0];
  assign head_time_o        = c_valid[0] ? c_time[0] : '0;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |=> !busy_q && result_valid_o)
    else $error("result beat missing after command");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_valid[1] |-> c_valid[0] && (c_time[0] <= c_time[1]))
    else $error("queue order broken at head");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o == teoq_pkg::STATUS_EMPTY) |-> !head_valid_o)
    else $error("empty status with nonempty queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o == teoq_pkg::STATUS_FULL) |-> c_valid[QUEUE_DEPTH-1])
    else $error("full status with free cell");

endmodule
`default_nettype wire

// ----- design/teoq_cell.sv -----
`default_nettype none
module teoq_cell #(
  parameter int unsigned TIME_BITS    = teoq_pkg::TIME_BITS_DEF,
  parameter int unsigned PROCESS_BITS = teoq_pkg::PROCESS_BITS_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire teoq_pkg::cell_ctrl_t        ctrl_i,
  input  wire [TIME_BITS-1:0]              cmp_time_i,
  input  wire [PROCESS_BITS-1:0]           cmp_proc_i,
  input  wire [TIME_BITS-1:0]              new_time_i,
  input  wire [PROCESS_BITS-1:0]           new_proc_i,
  input  wire [teoq_pkg::STATE_BITS-1:0]   new_os_i,
  input  wire [teoq_pkg::STATE_BITS-1:0]   new_ns_i,
  input  wire                              left_gt_i,
  input  wire                              left_valid_i,
  input  wire [TIME_BITS-1:0]              left_time_i,
  input  wire [PROCESS_BITS-1:0]           left_proc_i,
  input  wire [teoq_pkg::STATE_BITS-1:0]   left_os_i,
  input  wire [teoq_pkg::STATE_BITS-1:0]   left_ns_i,
  input  wire                              right_valid_i,
  input  wire [TIME_BITS-1:0]              right_time_i,
  input  wire [PROCESS_BITS-1:0]           right_proc_i,
  input  wire [teoq_pkg::STATE_BITS-1:0]   right_os_i,
  input  wire [teoq_pkg::STATE_BITS-1:0]   right_ns_i,
  input  wire                              shift_rem_i,
  output logic                             gt_o,
  output logic                             match_o,
  output logic                             valid_o,
  output logic [TIME_BITS-1:0]             time_o,
  output logic [PROCESS_BITS-1:0]          proc_o,
  output logic [teoq_pkg::STATE_BITS-1:0]  os_o,
  output logic [teoq_pkg::STATE_BITS-1:0]  ns_o
);

  logic                            valid_q, valid_d;
  logic [TIME_BITS-1:0]            time_q, time_d;
  logic [PROCESS_BITS-1:0]         proc_q, proc_d;
  logic [teoq_pkg::STATE_BITS-1:0] os_q, os_d;
  logic [teoq_pkg::STATE_BITS-1:0] ns_q, ns_d;
  logic                            gt_q, gt_d;
  logic                            match_q, match_d;
  logic                            take_left, take_new, take_right;

  // empty cells count as later than any timestamp
  always_comb begin
    gt_d    = gt_q;
    match_d = match_q;
    if (ctrl_i.sample) begin
      gt_d    = !valid_q || (time_q > cmp_time_i);
      match_d = valid_q && (proc_q == cmp_proc_i);
    end
  end

  always_comb begin
    take_left  = ctrl_i.add && left_gt_i;
    take_new   = ctrl_i.add && !left_gt_i && gt_q;
    take_right = ctrl_i.pop || (ctrl_i.rem && shift_rem_i);
  end

  always_comb begin
    valid_d = valid_q;
    time_d  = time_q;
    proc_d  = proc_q;
    os_d    = os_q;
    ns_d    = ns_q;
    priority if (take_left) begin
      valid_d = left_valid_i;
      time_d  = left_time_i;
      proc_d  = left_proc_i;
      os_d    = left_os_i;
      ns_d    = left_ns_i;
    end else if (take_new) begin
      valid_d = 1'b1;
      time_d  = new_time_i;
      proc_d  = new_proc_i;
      os_d    = new_os_i;
      ns_d    = new_ns_i;
    end else if (take_right) begin
      valid_d = right_valid_i;
      time_d  = right_time_i;
      proc_d  = right_proc_i;
      os_d    = right_os_i;
      ns_d    = right_ns_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      gt_q    <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      gt_q    <= gt_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    time_q <= time_d;
    proc_q <= proc_d;
    os_q   <= os_d;
    ns_q   <= ns_d;
  end

  assign gt_o    = gt_q;
  assign match_o = match_q;
  assign valid_o = valid_q;
  assign time_o  = time_q;
  assign proc_o  = proc_q;
  assign os_o    = os_q;
  assign ns_o    = ns_q;

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb;

  localparam int unsigned TW    = teoq_pkg::TIME_BITS_DEF;
  localparam int unsigned PW    = teoq_pkg::PROCESS_BITS_DEF;
  localparam int unsigned DEPTH = teoq_pkg::QUEUE_DEPTH_DEF;
  localparam int unsigned CW    = teoq_pkg::CMD_BITS;
  localparam int unsigned SW    = teoq_pkg::STATE_BITS;
  localparam int unsigned RW    = teoq_pkg::STATUS_BITS;
  localparam int RANDOM_CMDS    = 700;
  localparam int CYCLE_LIMIT    = 400000;

  typedef struct packed {
    logic [CW-1:0] cmd;
    logic [TW-1:0] stamp;
    logic [PW-1:0] pid;
    logic [SW-1:0] old_st;
    logic [SW-1:0] new_st;
    logic          hold_for_drain;
  } cmd_beat_t;

  typedef struct packed {
    logic [TW-1:0] stamp;
    logic [PW-1:0] pid;
    logic [SW-1:0] old_st;
    logic [SW-1:0] new_st;
  } queued_event_t;

  typedef struct packed {
    logic [RW-1:0] status;
    logic [TW-1:0] popped_time;
    logic [PW-1:0] popped_process;
    logic [SW-1:0] popped_old_state;
    logic [SW-1:0] popped_new_state;
    logic          head_valid;
    logic [TW-1:0] head_time;
  } queue_outcome_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  logic [CW-1:0] cmd_i = teoq_pkg::CMD_NONE;
  logic [TW-1:0] event_time_i = '0;
  logic [PW-1:0] process_id_i = '0;
  logic [SW-1:0] old_state_i = '0;
  logic [SW-1:0] new_state_i = '0;
  logic          result_valid_o;
  logic [RW-1:0] status_o;
  logic [TW-1:0] popped_time_o;
  logic [PW-1:0] popped_process_o;
  logic [SW-1:0] popped_old_state_o;
  logic [SW-1:0] popped_new_state_o;
  logic          head_valid_o;
  logic [TW-1:0] head_time_o;

  cmd_beat_t      pending_cmds[$];
  queued_event_t  event_order[$];
  queue_outcome_t expected_outcomes[$];

  int mismatches = 0;
  int cycle_count = 0;
  int results_seen = 0;
  int adds = 0, pops = 0, removes = 0, unused_cmds = 0;
  int full_drops = 0, empty_pops = 0, unmatched_removes = 0;
  int peak_depth = 0;
  int gap_left = 0;
  int burst_left = 0;

  timestamp_ordered_event_queue_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .cmd_i              (cmd_i),
    .event_time_i       (event_time_i),
    .process_id_i       (process_id_i),
    .old_state_i        (old_state_i),
    .new_state_i        (new_state_i),
    .result_valid_o     (result_valid_o),
    .status_o           (status_o),
    .popped_time_o      (popped_time_o),
    .popped_process_o   (popped_process_o),
    .popped_old_state_o (popped_old_state_o),
    .popped_new_state_o (popped_new_state_o),
    .head_valid_o       (head_valid_o),
    .head_time_o        (head_time_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // stable sorted insert, head pop, first-match remove
  function automatic queue_outcome_t apply_to_event_order(cmd_beat_t b);
    queue_outcome_t o;
    queued_event_t  e;
    int             pos;
    int             hit;
    o = '0;
    e = '{stamp: b.stamp, pid: b.pid, old_st: b.old_st, new_st: b.new_st};
    case (b.cmd)
      teoq_pkg::CMD_ADD: begin
        adds++;
        if (event_order.size() >= DEPTH) begin
          o.status = teoq_pkg::STATUS_FULL;
          full_drops++;
        end else begin
          pos = 0;
          while (pos < event_order.size() && event_order[pos].stamp <= b.stamp) pos++;
          event_order.insert(pos, e);
        end
      end
      teoq_pkg::CMD_POP: begin
        pops++;
        if (event_order.size() == 0) begin
          o.status = teoq_pkg::STATUS_EMPTY;
          empty_pops++;
        end else begin
          e = event_order[0];
          event_order.delete(0);
          o.popped_time      = e.stamp;
          o.popped_process   = e.pid;
          o.popped_old_state = e.old_st;
          o.popped_new_state = e.new_st;
        end
      end
      teoq_pkg::CMD_REMOVE: begin
        removes++;
        hit = -1;
        for (int k = 0; k < event_order.size() && hit < 0; k++) begin
          if (event_order[k].pid == b.pid) hit = k;
        end
        if (hit < 0) begin
          o.status = teoq_pkg::STATUS_NOT_FOUND;
          unmatched_removes++;
        end else begin
          event_order.delete(hit);
        end
      end
      default: begin
        unused_cmds++;
      end
    endcase
    o.head_valid = (event_order.size() != 0);
    o.head_time  = (event_order.size() != 0) ? event_order[0].stamp : '0;
    if (event_order.size() > peak_depth) peak_depth = event_order.size();
    return o;
  endfunction

  function automatic cmd_beat_t make_cmd(logic [CW-1:0] c, logic [TW-1:0] t,
                                         logic [PW-1:0] p, logic [SW-1:0] os,
                                         logic [SW-1:0] ns);
    cmd_beat_t b;
    b = '{cmd: c, stamp: t, pid: p, old_st: os, new_st: ns, hold_for_drain: 1'b0};
    return b;
  endfunction

  function automatic void add_pending(cmd_beat_t b);
    pending_cmds.insert(pending_cmds.size(), b);
  endfunction

  // stimulus
  initial begin
    int            made;
    int            phase_len;
    int            mode;
    int            roll;
    cmd_beat_t     b;
    logic [CW-1:0] c;

    add_pending(make_cmd(teoq_pkg::CMD_POP, 32'h1234_5678, 8'h11, 3'd1, 3'd2));
    add_pending(make_cmd(teoq_pkg::CMD_REMOVE, '0, 8'd5, 3'd0, 3'd0));
    add_pending(make_cmd(teoq_pkg::CMD_NONE, '1, '1, 3'd7, 3'd7));
    add_pending(make_cmd(teoq_pkg::CMD_ADD, '1, '1, 3'd7, 3'd7));
    add_pending(make_cmd(teoq_pkg::CMD_ADD, '0, '0, 3'd0, 3'd0));
    add_pending(make_cmd(teoq_pkg::CMD_ADD, 32'd100, 8'd1, 3'd0, 3'd2));
    add_pending(make_cmd(teoq_pkg::CMD_ADD, 32'd100, 8'd2, 3'd2, 3'd3));
    add_pending(make_cmd(teoq_pkg::CMD_ADD, 32'd100, 8'd3, 3'd3, 3'd4));
    add_pending(make_cmd(teoq_pkg::CMD_ADD, 32'd50, 8'd1, 3'd4, 3'd5));
    add_pending(make_cmd(teoq_pkg::CMD_NONE, 32'hA5A5_5A5A, 8'h5A, 3'd5, 3'd1));
    add_pending(make_cmd(teoq_pkg::CMD_REMOVE, '0, 8'd1, 3'd0, 3'd0));
    add_pending(make_cmd(teoq_pkg::CMD_REMOVE, '0, 8'd9, 3'd0, 3'd0));
    add_pending(make_cmd(teoq_pkg::CMD_REMOVE, '0, '1, 3'd0, 3'd0));
    add_pending(make_cmd(teoq_pkg::CMD_ADD, 32'd7, 8'd4, 3'd5, 3'd6));
    repeat (6) add_pending(make_cmd(teoq_pkg::CMD_POP, '0, '0, 3'd0, 3'd0));

    made = 0;
    while (made < RANDOM_CMDS) begin
      phase_len = $urandom_range(40, 110);
      mode = (made == 0) ? 0 : $urandom_range(0, 3);
      for (int i = 0; i < phase_len && made < RANDOM_CMDS; i++) begin
        roll = $urandom_range(0, 99);
        case (mode)
          0:       c = (roll < 88) ? teoq_pkg::CMD_ADD : (roll < 94) ? teoq_pkg::CMD_POP :
                       (roll < 98) ? teoq_pkg::CMD_REMOVE : teoq_pkg::CMD_NONE;
          1:       c = (roll < 15) ? teoq_pkg::CMD_ADD : (roll < 75) ? teoq_pkg::CMD_POP :
                       (roll < 97) ? teoq_pkg::CMD_REMOVE : teoq_pkg::CMD_NONE;
          default: c = (roll < 50) ? teoq_pkg::CMD_ADD : (roll < 75) ? teoq_pkg::CMD_POP :
                       (roll < 97) ? teoq_pkg::CMD_REMOVE : teoq_pkg::CMD_NONE;
        endcase
        b.cmd = c;
        if (mode == 3 || $urandom_range(0, 1) == 0) b.stamp = TW'($urandom_range(0, 7));
        else b.stamp = TW'($urandom);
        b.pid = ($urandom_range(0, 9) < 7) ? PW'($urandom_range(0, 7)) :
                                             PW'($urandom_range(0, 255));
        b.old_st = ($urandom_range(0, 9) == 0) ? SW'($urandom_range(0, 7)) :
                                                 SW'($urandom_range(0, 5));
        b.new_st = ($urandom_range(0, 9) == 0) ? SW'($urandom_range(0, 7)) :
                                                 SW'($urandom_range(0, 5));
        b.hold_for_drain = (i == 0) && (made == 0 || $urandom_range(0, 3) == 0);
        add_pending(b);
        made++;
      end
    end

    wait (rst_ni);
    wait (pending_cmds.size() == 0 && !start && expected_outcomes.size() == 0);
    repeat (8) @(posedge clk_i);
    $display("ran %0d commands: %0d adds (%0d dropped full), %0d pops (%0d empty),",
             adds + pops + removes + unused_cmds, adds, full_drops, pops, empty_pops);
    $display("%0d removes (%0d unmatched), %0d unused; peak depth %0d; %0d results checked",
             removes, unmatched_removes, unused_cmds, peak_depth, results_seen);
    if (mismatches == 0 && expected_outcomes.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // driver: bursts with random gaps, one beat per handshake
  always @(posedge clk_i) begin
    logic           accepted;
    logic           drive_start;
    cmd_beat_t      b;
    queue_outcome_t predicted;
    if (rst_ni) begin
      accepted = start && !busy;
      drive_start = start && !accepted;
      if (accepted) begin
        predicted = apply_to_event_order('{cmd: cmd_i, stamp: event_time_i,
            pid: process_id_i, old_st: old_state_i, new_st: new_state_i,
            hold_for_drain: 1'b0});
        expected_outcomes.insert(expected_outcomes.size(), predicted);
      end
      if (!drive_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (burst_left == 0) begin
          burst_left = $urandom_range(1, 60);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
        end else if (pending_cmds.size() != 0 &&
                     (!pending_cmds[0].hold_for_drain || expected_outcomes.size() == 0)) begin
          b = pending_cmds[0];
          pending_cmds.delete(0);
          drive_start = 1'b1;
          burst_left--;
          cmd_i        <= b.cmd;
          event_time_i <= b.stamp;
          process_id_i <= b.pid;
          old_state_i  <= b.old_st;
          new_state_i  <= b.new_st;
        end
      end
      start <= drive_start;
    end
  end

  // monitor: each result beat against the oldest prediction
  always @(posedge clk_i) begin
    queue_outcome_t got;
    queue_outcome_t want;
    if (rst_ni && result_valid_o) begin
      results_seen++;
      got = '{status: status_o, popped_time: popped_time_o,
              popped_process: popped_process_o, popped_old_state: popped_old_state_o,
              popped_new_state: popped_new_state_o, head_valid: head_valid_o,
              head_time: head_time_o};
      if (expected_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %p", got);
      end else begin
        want = expected_outcomes[0];
        expected_outcomes.delete(0);
        if (got.status !== want.status || got.popped_time !== want.popped_time ||
            got.popped_process !== want.popped_process ||
            got.popped_old_state !== want.popped_old_state ||
            got.popped_new_state !== want.popped_new_state ||
            got.head_valid !== want.head_valid || got.head_time !== want.head_time) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch on result %0d", results_seen);
            $display("  expected %p", want);
            $display("  actual   %p", got);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

endmodule
`default_nettype wire
